// ===== rtl/tcct_pkg.sv =====
// tcct_pkg: shared constants for the track candidate confirm table
// holds action, result and register codes, reset values and gate scale factors
// no dependencies
`default_nettype none

package tcct_pkg;

  // default geometry
  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned COORD_BITS_DEF    = 12;

  // configuration port
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 8;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AGE_CAP       = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_QUALIFY_COUNT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RATE_SCALE    = 2'd2;

  localparam logic [CFG_DATA_BITS-1:0] AGE_CAP_RST       = 8'd15;
  localparam logic [CFG_DATA_BITS-1:0] QUALIFY_COUNT_RST = 8'd4;
  localparam logic [CFG_DATA_BITS-1:0] RATE_SCALE_RST    = 8'd25;

  // actions
  localparam int unsigned ACTION_BITS = 2;
  localparam logic [ACTION_BITS-1:0] ACT_TICK    = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_FEED    = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_HARVEST = 2'd2;
  localparam logic [ACTION_BITS-1:0] ACT_NONE    = 2'd3;

  // result codes
  localparam int unsigned CODE_BITS = 3;
  localparam logic [CODE_BITS-1:0] RES_MATCHED   = 3'd0;
  localparam logic [CODE_BITS-1:0] RES_ADDED     = 3'd1;
  localparam logic [CODE_BITS-1:0] RES_DROPPED   = 3'd2;
  localparam logic [CODE_BITS-1:0] RES_TICK      = 3'd3;
  localparam logic [CODE_BITS-1:0] RES_HARVESTED = 3'd4;
  localparam logic [CODE_BITS-1:0] RES_NONE      = 3'd5;

  // gate: 100*rate^2*d^2 < 529*w^2, i.e. rate*d < 2.3*w
  localparam int unsigned RATE_SQ_SCALE  = 100;
  localparam int unsigned WIDTH_SQ_SCALE = 529;
  localparam int unsigned RS_SQ_BITS     = 2 * CFG_DATA_BITS;
  // 100 * 255^2 fits in 23 bits
  localparam int unsigned K_BITS         = 23;

  // per-entry counters
  localparam int unsigned COUNT_BITS = 8;

endpackage

`default_nettype wire

// ===== rtl/track_candidate_confirm_table.sv =====
// track_candidate_confirm_table: top level of the candidate window table
// depends on tcct_pkg and tcct_mul
`default_nettype none

// Table of unconfirmed detection windows kept oldest first in a single-port-read,
// single-port-write memory with a fill count (no clearing pass after reset).
// One transaction is taken at a time; in_ready is high only while the block is idle.
// A tick or harvest sweeps the table one entry at a time, reading and then evaluating
// each entry and compacting removed entries in place. A feed first derives the rate
// factor, then examines entries in order up to the first match, each through read, dx
// and dy squares, sum, scaled product, width square, scaled width and compare; this cost
// is set by the one shared multiplier, which forms each square and scaled product in turn.
// Results leave through an output register; extra cycles are added only while
// out_ready holds a result back.

module track_candidate_confirm_table
  import tcct_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned COORD_BITS    = COORD_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // configuration
  input  wire logic                      cfg_write_en,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  // input channel
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [ACTION_BITS-1:0]    action,
  input  wire logic [COORD_BITS-1:0]     win_x,
  input  wire logic [COORD_BITS-1:0]     win_y,
  input  wire logic [COORD_BITS-1:0]     win_w,
  input  wire logic [COORD_BITS-1:0]     win_h,
  // output channel
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [CODE_BITS-1:0]           result_code,
  output logic [COORD_BITS-1:0]          out_x,
  output logic [COORD_BITS-1:0]          out_y,
  output logic [COORD_BITS-1:0]          out_w,
  output logic [COORD_BITS-1:0]          out_h,
  output logic                           last_of_run
);

  localparam int unsigned C         = COORD_BITS;
  localparam int unsigned IDX_BITS  = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_BITS  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned CB        = C + 1;
  localparam int unsigned D2_BITS   = 2 * C + 3;
  localparam int unsigned MA        = D2_BITS;
  localparam int unsigned MB        = (C + 1 > K_BITS) ? C + 1 : K_BITS;
  localparam int unsigned P_BITS    = MA + MB;
  localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(TABLE_ENTRIES);

  // sequencer states
  localparam int unsigned ST_BITS = 5;
  localparam logic [ST_BITS-1:0] S_IDLE = 5'd0;
  localparam logic [ST_BITS-1:0] S_K1   = 5'd1;
  localparam logic [ST_BITS-1:0] S_K2   = 5'd2;
  localparam logic [ST_BITS-1:0] S_K3   = 5'd3;
  localparam logic [ST_BITS-1:0] S_FRD  = 5'd4;
  localparam logic [ST_BITS-1:0] S_FDX  = 5'd5;
  localparam logic [ST_BITS-1:0] S_FDY  = 5'd6;
  localparam logic [ST_BITS-1:0] S_FSUM = 5'd7;
  localparam logic [ST_BITS-1:0] S_FLHS = 5'd8;
  localparam logic [ST_BITS-1:0] S_FW   = 5'd9;
  localparam logic [ST_BITS-1:0] S_FW2  = 5'd10;
  localparam logic [ST_BITS-1:0] S_FCMP = 5'd11;
  localparam logic [ST_BITS-1:0] S_FEND = 5'd12;
  localparam logic [ST_BITS-1:0] S_CRD  = 5'd13;
  localparam logic [ST_BITS-1:0] S_CEV  = 5'd14;
  localparam logic [ST_BITS-1:0] S_CFIN = 5'd15;
  localparam logic [ST_BITS-1:0] S_EMIT = 5'd16;

  typedef struct packed {
    logic [C-1:0]          left;
    logic [C-1:0]          top;
    logic [C-1:0]          width;
    logic [C-1:0]          height;
    logic [COUNT_BITS-1:0] life;
    logic [COUNT_BITS-1:0] hits;
  } entry_t;

  // control and configuration registers
  logic [ST_BITS-1:0]       state;
  logic [CNT_BITS-1:0]      count;
  logic [CNT_BITS-1:0]      rp;
  logic [CNT_BITS-1:0]      wp;
  logic [CFG_DATA_BITS-1:0] age_cap;
  logic [CFG_DATA_BITS-1:0] qualify_count;
  logic [CFG_DATA_BITS-1:0] rate_scale;

  // working registers
  logic [ACTION_BITS-1:0] act;
  logic [C-1:0]           fx, fy, fw, fh;
  logic [K_BITS-1:0]      k_scale;
  logic [D2_BITS-1:0]     d2;
  logic [P_BITS-1:0]      lhs;
  logic                   pend_valid;
  logic [C-1:0]           pend_x, pend_y, pend_w, pend_h;
  logic [CODE_BITS-1:0]   em_code;
  logic [C-1:0]           em_x, em_y, em_w, em_h;

  // memory ports
  entry_t                 mem [TABLE_ENTRIES];
  entry_t                 mem_rdata;
  entry_t                 mem_wdata;
  logic                   mem_re, mem_we;
  logic [IDX_BITS-1:0]    mem_raddr, mem_waddr;

  // multiplier ports
  logic [MA-1:0]          mul_a;
  logic [MB-1:0]          mul_b;
  logic [P_BITS-1:0]      mul_prod;

  // output load
  logic                   out_load;
  logic [CODE_BITS-1:0]   ld_code;
  logic [C-1:0]           ld_x, ld_y, ld_w, ld_h;
  logic                   ld_last;

  // datapath helpers
  logic [CB-1:0]          cx, cy, ex, ey, dx, dy;
  logic [COUNT_BITS-1:0]  life_inc, hits_inc;
  logic                   out_free;
  logic                   more;
  logic                   gate_hit;
  logic                   keep_tick;
  logic                   qual;

  tcct_mul #(
    .A_BITS(MA),
    .B_BITS(MB)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .prod(mul_prod)
  );

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // centers, distances and saturating counters
  assign cx = CB'(fx) + CB'(fw[C-1:1]);
  assign cy = CB'(fy) + CB'(fh[C-1:1]);
  assign ex = CB'(mem_rdata.left) + CB'(mem_rdata.width[C-1:1]);
  assign ey = CB'(mem_rdata.top) + CB'(mem_rdata.height[C-1:1]);
  assign dx = (cx > ex) ? cx - ex : ex - cx;
  assign dy = (cy > ey) ? cy - ey : ey - cy;
  assign life_inc = (&mem_rdata.life) ? mem_rdata.life : mem_rdata.life + 1'b1;
  assign hits_inc = (&mem_rdata.hits) ? mem_rdata.hits : mem_rdata.hits + 1'b1;

  assign out_free  = !out_valid || out_ready;
  assign more      = rp < count;
  assign gate_hit  = lhs < mul_prod;
  assign keep_tick = !(mem_rdata.life > age_cap);
  assign qual      = mem_rdata.hits > qualify_count;
  assign in_ready  = (state == S_IDLE);

  // memory, multiplier and output steering per state
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = rp[IDX_BITS-1:0];
    mem_we    = 1'b0;
    mem_waddr = wp[IDX_BITS-1:0];
    mem_wdata = mem_rdata;
    mul_a     = '0;
    mul_b     = '0;
    out_load  = 1'b0;
    ld_code   = em_code;
    ld_x      = em_x;
    ld_y      = em_y;
    ld_w      = em_w;
    ld_h      = em_h;
    ld_last   = 1'b1;
    case (state)
      S_K1: begin
        mul_a = MA'(rate_scale);
        mul_b = MB'(rate_scale);
      end
      S_K2: begin
        mul_a = MA'(mul_prod[RS_SQ_BITS-1:0]);
        mul_b = MB'(RATE_SQ_SCALE);
      end
      S_FRD, S_CRD: begin
        mem_re = more;
      end
      S_FDX: begin
        mul_a = MA'(dx);
        mul_b = MB'(dx);
      end
      S_FDY: begin
        mul_a = MA'(dy);
        mul_b = MB'(dy);
      end
      S_FLHS: begin
        mul_a = d2;
        mul_b = MB'(k_scale);
      end
      S_FW: begin
        mul_a = MA'(mem_rdata.width);
        mul_b = MB'(mem_rdata.width);
      end
      S_FW2: begin
        mul_a = MA'(mul_prod[2*C-1:0]);
        mul_b = MB'(WIDTH_SQ_SCALE);
      end
      S_FCMP: begin
        // matched entry takes the fed window
        if (gate_hit) begin
          mem_we    = 1'b1;
          mem_waddr = rp[IDX_BITS-1:0];
          mem_wdata = '{left: fx, top: fy, width: fw, height: fh,
                        life: mem_rdata.life, hits: hits_inc};
        end
      end
      S_FEND: begin
        // append at the tail when there is room
        if (count < FULL_COUNT) begin
          mem_we    = 1'b1;
          mem_waddr = count[IDX_BITS-1:0];
          mem_wdata = '{left: fx, top: fy, width: fw, height: fh,
                        life: '0, hits: '0};
        end
      end
      S_CEV: begin
        if (act == ACT_TICK) begin
          if (keep_tick) begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata;
            mem_wdata.life = life_inc;
          end
        end else if (!qual) begin
          mem_we = 1'b1;
        end else if (pend_valid && out_free) begin
          // earlier harvested window goes out, not the last one
          out_load = 1'b1;
          ld_code  = RES_HARVESTED;
          ld_x     = pend_x;
          ld_y     = pend_y;
          ld_w     = pend_w;
          ld_h     = pend_h;
          ld_last  = 1'b0;
        end
      end
      S_EMIT: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      result_code <= ld_code;
      out_x       <= ld_x;
      out_y       <= ld_y;
      out_w       <= ld_w;
      out_h       <= ld_h;
      last_of_run <= ld_last;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      rp         <= '0;
      wp         <= '0;
      pend_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            rp         <= '0;
            wp         <= '0;
            pend_valid <= 1'b0;
            case (action)
              ACT_TICK, ACT_HARVEST: state <= S_CRD;
              ACT_FEED:              state <= S_K1;
              default:               state <= S_IDLE;
            endcase
          end
        end
        S_K1: state <= S_K2;
        S_K2: state <= S_K3;
        S_K3: state <= S_FRD;
        S_FRD: state <= more ? S_FDX : S_FEND;
        S_FDX: state <= S_FDY;
        S_FDY: state <= S_FSUM;
        S_FSUM: state <= S_FLHS;
        S_FLHS: state <= S_FW;
        S_FW: state <= S_FW2;
        S_FW2: state <= S_FCMP;
        S_FCMP: begin
          if (gate_hit) begin
            state <= S_EMIT;
          end else begin
            rp    <= rp + 1'b1;
            state <= S_FRD;
          end
        end
        S_FEND: begin
          if (count < FULL_COUNT) begin
            count <= count + 1'b1;
          end
          state <= S_EMIT;
        end
        S_CRD: state <= more ? S_CEV : S_CFIN;
        S_CEV: begin
          if (act == ACT_TICK) begin
            if (keep_tick) begin
              wp <= wp + 1'b1;
            end
            rp    <= rp + 1'b1;
            state <= S_CRD;
          end else if (!qual) begin
            wp    <= wp + 1'b1;
            rp    <= rp + 1'b1;
            state <= S_CRD;
          end else if (!pend_valid || out_free) begin
            pend_valid <= 1'b1;
            rp         <= rp + 1'b1;
            state      <= S_CRD;
          end
        end
        S_CFIN: begin
          count <= wp;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // working data, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          act <= action;
          fx  <= win_x;
          fy  <= win_y;
          fw  <= win_w;
          fh  <= win_h;
        end
      end
      S_K3: k_scale <= mul_prod[K_BITS-1:0];
      S_FDY: d2 <= mul_prod[D2_BITS-1:0];
      S_FSUM: d2 <= d2 + mul_prod[D2_BITS-1:0];
      S_FW: lhs <= mul_prod;
      S_FCMP: begin
        em_code <= RES_MATCHED;
        em_x    <= fx;
        em_y    <= fy;
        em_w    <= fw;
        em_h    <= fh;
      end
      S_FEND: begin
        em_code <= (count < FULL_COUNT) ? RES_ADDED : RES_DROPPED;
        em_x    <= fx;
        em_y    <= fy;
        em_w    <= fw;
        em_h    <= fh;
      end
      S_CEV: begin
        if (act != ACT_TICK && qual && (!pend_valid || out_free)) begin
          pend_x <= mem_rdata.left;
          pend_y <= mem_rdata.top;
          pend_w <= mem_rdata.width;
          pend_h <= mem_rdata.height;
        end
      end
      S_CFIN: begin
        if (act == ACT_TICK) begin
          em_code <= RES_TICK;
          em_x    <= '0;
          em_y    <= '0;
          em_w    <= '0;
          em_h    <= '0;
        end else if (pend_valid) begin
          em_code <= RES_HARVESTED;
          em_x    <= pend_x;
          em_y    <= pend_y;
          em_w    <= pend_w;
          em_h    <= pend_h;
        end else begin
          em_code <= RES_NONE;
          em_x    <= '0;
          em_y    <= '0;
          em_w    <= '0;
          em_h    <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      age_cap       <= AGE_CAP_RST;
      qualify_count <= QUALIFY_COUNT_RST;
      rate_scale    <= RATE_SCALE_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_AGE_CAP:       age_cap       <= cfg_data;
        REG_QUALIFY_COUNT: qualify_count <= cfg_data;
        REG_RATE_SCALE:    rate_scale    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tcct_mul.sv =====
// tcct_mul: shared unsigned multiplier with a registered product
// used by the gate sequencer for every square and scale product
// depends on nothing
`default_nettype none

module tcct_mul #(
  parameter int unsigned A_BITS = 27,
  parameter int unsigned B_BITS = 23
) (
  input  wire logic                     clk,
  input  wire logic [A_BITS-1:0]        a,
  input  wire logic [B_BITS-1:0]        b,
  output logic      [A_BITS+B_BITS-1:0] prod
);

  // product is registered from the operands
  always_ff @(posedge clk) begin
    prod <= (A_BITS+B_BITS)'(a) * (A_BITS+B_BITS)'(b);
  end

endmodule

`default_nettype wire

// ===== rtl/tcct_checker.sv =====
// tcct_checker: port-level assertions for the candidate confirm table
// depends on tcct_pkg; bound to track_candidate_confirm_table below
`default_nettype none

module tcct_checker
  import tcct_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic [ACTION_BITS-1:0]    action,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [CODE_BITS-1:0]      result_code,
  input wire logic [COORD_BITS-1:0]     out_x,
  input wire logic [COORD_BITS-1:0]     out_y,
  input wire logic [COORD_BITS-1:0]     out_w,
  input wire logic [COORD_BITS-1:0]     out_h,
  input wire logic                      last_of_run
);

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({result_code, out_x, out_y, out_w, out_h, last_of_run}))
    else $error("stalled result changed");

  // an accepted real action drops in_ready in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action != ACT_NONE |=> !in_ready)
    else $error("ready right after an accepted action");

  // only a harvest produces more than one result
  a_multi_harvest: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> result_code == RES_HARVESTED)
    else $error("non-final result that is not a harvested window");

  // tick and empty harvest carry a zero window
  a_zero_window: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_code == RES_TICK || result_code == RES_NONE) |->
      out_x == '0 && out_y == '0 && out_w == '0 && out_h == '0 && last_of_run)
    else $error("status result with a nonzero window");

endmodule

bind track_candidate_confirm_table tcct_checker #(
  .COORD_BITS(COORD_BITS)
) u_tcct_checker (.*);

`default_nettype wire
